>>> src/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
// No dependencies; every other file of the block but wgm_result_if refers to this package.
package wgm_pkg;

    // Default pattern capacity in bytes
    localparam int PATTERN_MAX_DEF = 32;

    localparam int CH_W = 8;

    // Pattern metacharacters
    localparam logic [CH_W-1:0] STAR_CH = 8'h2A;
    localparam logic [CH_W-1:0] ANY_CH  = 8'h3F;

    // Item commands
    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_CLEAR   = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_END     = 2'd3
    } cmd_t;

    // One registered item handed to the engine
    typedef struct packed {
        logic            fire;
        cmd_t            cmd;
        logic [CH_W-1:0] ch;
    } step_t;

    // Verdict given by the engine for the current subject
    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } verdict_t;

endpackage

>>> src/wgm_item_if.sv
// Input channel of the glob matcher: valid/ready with a command and a byte.
// Depends on wgm_pkg.
interface wgm_item_if;
    logic                      valid;
    logic                      ready;
    wgm_pkg::cmd_t             cmd;
    logic [wgm_pkg::CH_W-1:0]  ch;

    modport source (output valid, output cmd, output ch, input ready);
    modport sink   (input valid, input cmd, input ch, output ready);
endinterface

>>> src/wgm_result_if.sv
// Result channel of the glob matcher: valid/ready with the match verdict.
// No package dependency.
interface wgm_result_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

>>> src/wgm_star_close.sv
// Star closure of an active-position set: activity runs forward through stars.
// Parallel-prefix form, log2 levels deep. Depends on wgm_pkg for the default size.
module wgm_star_close #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
    input  logic [PATTERN_MAX:0]   set_in,
    input  logic [PATTERN_MAX-1:0] star,
    output logic [PATTERN_MAX:0]   set_out
);

    localparam int W = PATTERN_MAX + 1;

    // c[i] = s[i] | (star[i-1] & c[i-1]), solved as a carry-style prefix
    always_comb
    begin
        logic [W-1:0] g;
        logic [W-1:0] p;
        g = set_in;
        p = {star, 1'b0};
        for (int d = 1; d < W; d = d * 2)
        begin
            g = g | (p & (g << d));
            p = p & (p << d);
        end
        set_out = g;
    end

endmodule

>>> src/wgm_engine.sv
// Pattern store, active-position set and overflow flag of the glob matcher.
// Depends on wgm_pkg and wgm_star_close.
module wgm_engine #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wgm_pkg::step_t    step,
    output wgm_pkg::verdict_t verdict
);

    localparam int W  = PATTERN_MAX + 1;
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [LW-1:0] LEN_MAX = LW'(PATTERN_MAX);

    logic [wgm_pkg::CH_W-1:0] pat_reg [PATTERN_MAX];
    logic [LW-1:0]            len_reg, len_next;
    logic [W-1:0]             act_reg, act_next;
    logic                     ovf_reg, ovf_next;

    logic                     room;
    logic                     do_write;
    logic [W-1:0]             subj_set;
    logic [W-1:0]             close_in;
    logic [PATTERN_MAX-1:0]   star_vec;

    assign room     = (len_reg < LEN_MAX);
    assign do_write = step.fire && (step.cmd == wgm_pkg::CMD_APPEND) && room;

    // Advance active positions by one subject byte
    always_comb
    begin
        logic                     in_pat;
        logic [wgm_pkg::CH_W-1:0] pb;
        subj_set = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            in_pat = (LW'(i) < len_reg);
            pb     = pat_reg[i];
            if (in_pat && act_reg[i])
            begin
                if (pb == wgm_pkg::STAR_CH)
                    subj_set[i] = 1'b1;
                else if (pb == wgm_pkg::ANY_CH || pb == step.ch)
                    subj_set[i+1] = 1'b1;
            end
        end
    end

    // Length and overflow after this item
    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (step.fire)
        begin
            case (step.cmd)
                wgm_pkg::CMD_APPEND:
                begin
                    if (room)
                        len_next = len_reg + LW'(1);
                    else
                        ovf_next = 1'b1;
                end
                wgm_pkg::CMD_CLEAR:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                default:
                begin
                    len_next = len_reg;
                    ovf_next = ovf_reg;
                end
            endcase
        end
    end

    // Star mask of the pattern as it stands after this item
    always_comb
    begin
        logic is_star;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (do_write && LW'(i) == len_reg)
                is_star = (step.ch == wgm_pkg::STAR_CH);
            else
                is_star = (pat_reg[i] == wgm_pkg::STAR_CH);
            star_vec[i] = is_star && (LW'(i) < len_next);
        end
    end

    // Subject bytes advance the set; every other command re-arms at position zero
    assign close_in = (step.cmd == wgm_pkg::CMD_SUBJECT) ? subj_set : W'(1);

    wgm_star_close #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_close (
        .set_in  (close_in),
        .star    (star_vec),
        .set_out (act_next)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
            act_reg <= W'(1);
        end
        else if (step.fire)
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
            act_reg <= act_next;
        end
    end

    // Pattern bytes, written at the current length
    always_ff @(posedge clk)
    begin
        if (do_write)
            pat_reg[len_reg[IW-1:0]] <= step.ch;
    end

    assign verdict.matched          = act_reg[len_reg] && !ovf_reg;
    assign verdict.pattern_overflow = ovf_reg;

endmodule

>>> src/wildcard_glob_matcher_core.sv
// An end-subject item is accepted into the input register; when it leaves that register,
// its verdict is loaded into the result register, which then offers it on the result channel.
// Throughput: one item per cycle while nothing stalls; pattern, subject and end items all pass
// through the single update stage between the input register and the result register.
// Only end-subject items stall, and only while the result register holds an untaken result.
// Reset (rst_n, async, active low): empty pattern, overflow clear, both registers empty.
// Top level of the glob matcher. Depends on wgm_pkg, the interfaces and wgm_engine.
module wildcard_glob_matcher_core #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    wgm_item_if.sink    item,
    wgm_result_if.source result
);

    logic                     in_valid_reg, in_valid_next;
    wgm_pkg::cmd_t            in_cmd_reg;
    logic [wgm_pkg::CH_W-1:0] in_ch_reg;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_matched_reg;
    logic                     out_ovf_reg;

    logic                     out_free;
    logic                     advance;
    logic                     is_end;
    wgm_pkg::step_t           step;
    wgm_pkg::verdict_t        verdict;

    // Handshake control
    assign is_end     = (in_cmd_reg == wgm_pkg::CMD_END);
    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && (!is_end || out_free);
    assign item.ready = !in_valid_reg || advance;

    assign step.fire = advance;
    assign step.cmd  = in_cmd_reg;
    assign step.ch   = in_ch_reg;

    wgm_engine #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .verdict (verdict)
    );

    // Next valid flags
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item.ready)
            in_valid_next = item.valid;

        out_valid_next = out_valid_reg;
        if (advance && is_end)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_cmd_reg <= item.cmd;
            in_ch_reg  <= item.ch;
        end
        if (advance && is_end)
        begin
            out_matched_reg <= verdict.matched;
            out_ovf_reg     <= verdict.pattern_overflow;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.matched          = out_matched_reg;
    assign result.pattern_overflow = out_ovf_reg;

`ifndef SYNTH
    // A new result comes only from an end-subject item leaving the input register
    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && is_end))
        else $error("result raised without an end-subject item");

    // A blocked end-subject item stays in the input register
    a_end_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && is_end && out_valid_reg && !result.ready)
        |=> (in_valid_reg && is_end))
        else $error("end-subject item lost while result was stalled");

    // Overflow forces a no-match verdict
    a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_matched_reg && out_ovf_reg))
        else $error("match reported with pattern overflow");

    // Input side only stalls with a held item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (in_valid_reg && is_end && !out_free))
        else $error("input stalled without a blocked end-subject item");
`endif

endmodule
